@@ rtl/occ_pkg.sv @@
// Shared types and constants of the occurrence count statistics block.
package occ_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [16:0] MIN_EMPTY = 17'h10000;
	localparam logic [15:0] SAT16 = 16'hFFFF;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] entry_key;
		logic [15:0]        entry_count;
		logic               last_entry;
	} entry_t;

	typedef struct packed {
		logic        keep;
		logic [15:0] count;
		logic        last;
	} qitem_t;

	typedef struct packed {
		logic [15:0] distinct_count;
		logic [31:0] total_occurrences;
		logic [15:0] unique_count;
		logic [15:0] shared_count;
		logic [15:0] largest_first;
		logic [15:0] largest_second;
		logic [15:0] largest_third;
		logic [15:0] smallest_first;
		logic [15:0] smallest_second;
		logic [15:0] smallest_third;
	} result_t;

endpackage

@@ rtl/occurrence_count_statistics.sv @@
// Top level of the occurrence count statistics block.
// An entry transaction is taken every cycle while the four-entry queue has room.
// An accepted last entry is queued; the back end counts it when it pops it,
// which a stalled pending result holds off, and loads its result at that pop.
// Results leave through one output register; one set result per last entry.
// Asynchronous reset clears the mode, the queue, the statistics and the result valid flag.
module occurrence_count_statistics (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data,
	input  logic             entry_valid,
	output logic             entry_stall,
	input  occ_pkg::entry_t  entry,
	output logic             result_valid,
	input  logic             result_stall,
	output occ_pkg::result_t result
);

	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_not_empty;
	occ_pkg::qitem_t push_item;
	occ_pkg::qitem_t head_item;

	occ_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.entry_valid (entry_valid),
		.entry_stall (entry_stall),
		.entry       (entry),
		.queue_full  (queue_full),
		.push        (push),
		.push_item   (push_item)
	);

	occ_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.pop       (pop),
		.head_item (head_item)
	);

	occ_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (queue_not_empty),
		.item         (head_item),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ rtl/occ_front.sv @@
// Front end: holds the key sign mode and classifies each accepted entry.
module occ_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	input  logic            entry_valid,
	output logic            entry_stall,
	input  occ_pkg::entry_t entry,
	input  logic            queue_full,
	output logic            push,
	output occ_pkg::qitem_t push_item
);

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	assign entry_stall = queue_full;
	assign push        = entry_valid && !queue_full;

	always_comb begin
		push_item.keep  = (entry.entry_key != 32'sd0) &&
			(mode_q ? !entry.entry_key[31] : entry.entry_key[31]);
		push_item.count = entry.entry_count;
		push_item.last  = entry.last_entry;
	end

endmodule

@@ rtl/occ_queue.sv @@
// Short queue of classified entries between the front and back ends.
module occ_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  occ_pkg::qitem_t push_item,
	output logic            full,
	output logic            not_empty,
	input  logic            pop,
	output occ_pkg::qitem_t head_item
);

	occ_pkg::qitem_t             slot_q [occ_pkg::QDEPTH];
	logic [occ_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [occ_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [occ_pkg::QCNT_W-1:0]  count_q;

	assign full      = (count_q == occ_pkg::QCNT_W'(occ_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == occ_pkg::QPTR_W'(occ_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == occ_pkg::QPTR_W'(occ_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= occ_pkg::QCNT_W'(occ_pkg::QDEPTH))
		else $error("queue occupancy beyond its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue popped while empty");

endmodule

@@ rtl/occ_back.sv @@
// Back end: accumulates the statistics of a set and holds the result register.
module occ_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  occ_pkg::qitem_t  item,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output occ_pkg::result_t result
);

	logic [15:0] acc_distinct_q;
	logic [31:0] acc_total_q;
	logic [15:0] acc_unique_q;
	logic [15:0] acc_shared_q;
	logic [15:0] top_max_q [3];
	logic [16:0] top_min_q [3];
	logic        result_valid_q;
	occ_pkg::result_t result_q;

	logic [15:0] nx_distinct;
	logic [31:0] nx_total;
	logic [15:0] nx_unique;
	logic [15:0] nx_shared;
	logic [15:0] nx_max [3];
	logic [16:0] nx_min [3];
	logic [32:0] sum;
	logic [16:0] cnt17;
	logic        emit;

	assign pop  = item_valid && (!item.last || !result_valid_q || !result_stall);
	assign emit = pop && item.last;

	always_comb begin
		nx_distinct = acc_distinct_q;
		nx_total    = acc_total_q;
		nx_unique   = acc_unique_q;
		nx_shared   = acc_shared_q;
		nx_max      = top_max_q;
		nx_min      = top_min_q;
		sum         = {1'b0, acc_total_q} + {17'd0, item.count};
		cnt17       = {1'b0, item.count};
		if (item.keep) begin
			if (acc_distinct_q != occ_pkg::SAT16) begin
				nx_distinct = acc_distinct_q + 1'b1;
			end
			nx_total = sum[32] ? occ_pkg::SAT32 : sum[31:0];
			if (item.count == 16'd1) begin
				if (acc_unique_q != occ_pkg::SAT16) begin
					nx_unique = acc_unique_q + 1'b1;
				end
			end else if (acc_shared_q != occ_pkg::SAT16) begin
				nx_shared = acc_shared_q + 1'b1;
			end
			if (item.count >= top_max_q[0]) begin
				nx_max[2] = top_max_q[1];
				nx_max[1] = top_max_q[0];
				nx_max[0] = item.count;
			end else if (item.count >= top_max_q[1]) begin
				nx_max[2] = top_max_q[1];
				nx_max[1] = item.count;
			end else if (item.count >= top_max_q[2]) begin
				nx_max[2] = item.count;
			end
			if (cnt17 <= top_min_q[0]) begin
				nx_min[2] = top_min_q[1];
				nx_min[1] = top_min_q[0];
				nx_min[0] = cnt17;
			end else if (cnt17 <= top_min_q[1]) begin
				nx_min[2] = top_min_q[1];
				nx_min[1] = cnt17;
			end else if (cnt17 <= top_min_q[2]) begin
				nx_min[2] = cnt17;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_distinct_q <= '0;
			acc_total_q    <= '0;
			acc_unique_q   <= '0;
			acc_shared_q   <= '0;
			top_max_q      <= '{3{16'd0}};
			top_min_q      <= '{3{occ_pkg::MIN_EMPTY}};
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				acc_distinct_q <= '0;
				acc_total_q    <= '0;
				acc_unique_q   <= '0;
				acc_shared_q   <= '0;
				top_max_q      <= '{3{16'd0}};
				top_min_q      <= '{3{occ_pkg::MIN_EMPTY}};
			end else if (pop) begin
				acc_distinct_q <= nx_distinct;
				acc_total_q    <= nx_total;
				acc_unique_q   <= nx_unique;
				acc_shared_q   <= nx_shared;
				top_max_q      <= nx_max;
				top_min_q      <= nx_min;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.distinct_count    <= nx_distinct;
			result_q.total_occurrences <= nx_total;
			result_q.unique_count      <= nx_unique;
			result_q.shared_count      <= nx_shared;
			result_q.largest_first     <= nx_max[0];
			result_q.largest_second    <= nx_max[1];
			result_q.largest_third     <= nx_max[2];
			result_q.smallest_first    <= nx_min[0][16] ? 16'd0 : nx_min[0][15:0];
			result_q.smallest_second   <= nx_min[1][16] ? 16'd0 : nx_min[1][15:0];
			result_q.smallest_third    <= nx_min[2][16] ? 16'd0 : nx_min[2][15:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (acc_distinct_q == '0) && (acc_total_q == '0) &&
			(top_min_q[0] == occ_pkg::MIN_EMPTY) && result_valid_q)
		else $error("set not cleared or result not loaded after the last transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		(top_max_q[0] >= top_max_q[1]) && (top_max_q[1] >= top_max_q[2]) &&
		(top_min_q[0] <= top_min_q[1]) && (top_min_q[1] <= top_min_q[2]))
		else $error("ranked counts out of order");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |-> !emit)
		else $error("result overwritten while still pending");

endmodule

@@ dv/tb_occurrence_count_statistics.sv @@
// Self-checking testbench for the occurrence count statistics block.
module tb_occurrence_count_statistics;

	localparam int WATCHDOG_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS = 160;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic             cfg_wr_data = 1'b0;
	logic             entry_valid = 1'b0;
	logic             entry_stall;
	occ_pkg::entry_t  entry = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	occ_pkg::result_t result;

	occ_pkg::entry_t  entry_backlog[$];
	occ_pkg::result_t expected_sets[$];

	int unsigned send_idle_pct = 0;
	int unsigned result_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned sets_checked = 0;
	int unsigned entries_taken = 0;
	int unsigned mode_writes = 0;
	int unsigned cycles = 0;

	logic        keep_positive = 1'b0;
	logic [15:0] n_distinct;
	logic [31:0] n_total;
	logic [15:0] n_unique;
	logic [15:0] n_shared;
	logic [15:0] hi_cnt[3];
	logic [16:0] lo_cnt[3];

	string field_names[10] = '{"distinct_count", "total_occurrences", "unique_count",
		"shared_count", "largest_first", "largest_second", "largest_third",
		"smallest_first", "smallest_second", "smallest_third"};

	occurrence_count_statistics u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.entry_valid  (entry_valid),
		.entry_stall  (entry_stall),
		.entry        (entry),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	function automatic void clear_stats();
		n_distinct = '0;
		n_total = '0;
		n_unique = '0;
		n_shared = '0;
		for (int k = 0; k < 3; k++) begin
			hi_cnt[k] = '0;
			lo_cnt[k] = occ_pkg::MIN_EMPTY;
		end
	endfunction

	function automatic void absorb_count(logic [15:0] c);
		if (n_distinct != occ_pkg::SAT16) n_distinct++;
		n_total = (n_total > occ_pkg::SAT32 - {16'd0, c}) ?
			occ_pkg::SAT32 : n_total + {16'd0, c};
		if (c == 16'd1) begin
			if (n_unique != occ_pkg::SAT16) n_unique++;
		end else begin
			if (n_shared != occ_pkg::SAT16) n_shared++;
		end
		if (c >= hi_cnt[0]) begin
			hi_cnt[2] = hi_cnt[1];
			hi_cnt[1] = hi_cnt[0];
			hi_cnt[0] = c;
		end else if (c >= hi_cnt[1]) begin
			hi_cnt[2] = hi_cnt[1];
			hi_cnt[1] = c;
		end else if (c >= hi_cnt[2]) begin
			hi_cnt[2] = c;
		end
		if ({1'b0, c} <= lo_cnt[0]) begin
			lo_cnt[2] = lo_cnt[1];
			lo_cnt[1] = lo_cnt[0];
			lo_cnt[0] = {1'b0, c};
		end else if ({1'b0, c} <= lo_cnt[1]) begin
			lo_cnt[2] = lo_cnt[1];
			lo_cnt[1] = {1'b0, c};
		end else if ({1'b0, c} <= lo_cnt[2]) begin
			lo_cnt[2] = {1'b0, c};
		end
	endfunction

	function automatic logic [15:0] shown_min(logic [16:0] v);
		return (v >= occ_pkg::MIN_EMPTY) ? 16'd0 : v[15:0];
	endfunction

	function automatic occ_pkg::result_t snapshot_stats();
		occ_pkg::result_t r;
		r.distinct_count = n_distinct;
		r.total_occurrences = n_total;
		r.unique_count = n_unique;
		r.shared_count = n_shared;
		r.largest_first = hi_cnt[0];
		r.largest_second = hi_cnt[1];
		r.largest_third = hi_cnt[2];
		r.smallest_first = shown_min(lo_cnt[0]);
		r.smallest_second = shown_min(lo_cnt[1]);
		r.smallest_third = shown_min(lo_cnt[2]);
		return r;
	endfunction

	function automatic logic [31:0] field_of(occ_pkg::result_t r, int k);
		case (k)
			0: return {16'd0, r.distinct_count};
			1: return r.total_occurrences;
			2: return {16'd0, r.unique_count};
			3: return {16'd0, r.shared_count};
			4: return {16'd0, r.largest_first};
			5: return {16'd0, r.largest_second};
			6: return {16'd0, r.largest_third};
			7: return {16'd0, r.smallest_first};
			8: return {16'd0, r.smallest_second};
			default: return {16'd0, r.smallest_third};
		endcase
	endfunction

	task automatic check_set(occ_pkg::result_t want, occ_pkg::result_t got);
		logic [31:0] w;
		logic [31:0] g;
		for (int k = 0; k < 10; k++) begin
			w = field_of(want, k);
			g = field_of(got, k);
			if (w !== g) begin
				if (mismatches < 10)
					$display("Set %0d, %s: expected %0d, got %0d",
						sets_checked, field_names[k], w, g);
				mismatches++;
			end
		end
	endtask

	function automatic occ_pkg::entry_t make_entry(logic [31:0] key, logic [15:0] cnt,
		logic last);
		occ_pkg::entry_t e;
		e.entry_key = key;
		e.entry_count = cnt;
		e.last_entry = last;
		return e;
	endfunction

	function automatic logic [31:0] pick_key(logic keep_pos);
		logic [31:0] k;
		int unsigned sel;
		k = $urandom();
		sel = $urandom_range(19);
		if (sel < 14) k[31] = ~keep_pos;
		else if (sel < 17) k[31] = keep_pos;
		else if (sel == 17) k = '0;
		else k = keep_pos ? 32'h7FFF_FFFF : 32'h8000_0000;
		return k;
	endfunction

	function automatic logic [15:0] pick_count();
		int unsigned sel;
		sel = $urandom_range(15);
		if (sel < 4) return 16'd1;
		if (sel == 4) return 16'hFFFF;
		if (sel == 5) return 16'd0;
		if (sel < 10) return 16'($urandom_range(2, 8));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic queue_random_sets(int n, logic keep_pos);
		int left;
		int len;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			for (int i = 0; i < len && left > 0; i++) begin
				entry_backlog.push_back(make_entry(pick_key(keep_pos), pick_count(),
					i == len - 1));
				left--;
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (entry_backlog.size() != 0 || entry_valid || expected_sets.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(logic m);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_writes++;
	endtask

	task automatic set_pacing(int profile);
		case (profile)
			0: begin send_idle_pct = 0; result_stall_pct = 0; end
			1: begin send_idle_pct = 56; result_stall_pct = 0; end
			2: begin send_idle_pct = 0; result_stall_pct = 56; end
			default: begin send_idle_pct = 9; result_stall_pct = 9; end
		endcase
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > WATCHDOG_CYCLES) begin
			$display("occurrence_count_statistics verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			entry_valid <= 1'b0;
		end else if (!entry_valid || !entry_stall) begin
			if (entry_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				entry <= entry_backlog.pop_front();
				entry_valid <= 1'b1;
			end else begin
				entry_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < result_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) keep_positive = cfg_wr_data;
			if (entry_valid && !entry_stall) begin
				entries_taken++;
				if (entry.entry_key != 0 && (entry.entry_key[31] ^ keep_positive))
					absorb_count(entry.entry_count);
				if (entry.last_entry) begin
					expected_sets.push_back(snapshot_stats());
					clear_stats();
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_sets.size() == 0) begin
					if (mismatches < 10)
						$display("Result transaction with no set pending: %p", result);
					mismatches++;
				end else begin
					check_set(expected_sets.pop_front(), result);
				end
				sets_checked++;
			end
		end
	end

	initial begin
		clear_stats();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_mode(1'b1);
		set_pacing(0);
		entry_backlog.push_back(make_entry(0, 16'd5, 1'b1));
		entry_backlog.push_back(make_entry(1, 16'd1, 1'b0));
		entry_backlog.push_back(make_entry(32'h7FFF_FFFF, 16'hFFFF, 1'b0));
		entry_backlog.push_back(make_entry(-1, 16'd7, 1'b0));
		entry_backlog.push_back(make_entry(5, 16'hFFFF, 1'b0));
		entry_backlog.push_back(make_entry(3, 16'd1, 1'b0));
		entry_backlog.push_back(make_entry(9, 16'd0, 1'b0));
		entry_backlog.push_back(make_entry(32'h8000_0000, 16'd100, 1'b1));
		entry_backlog.push_back(make_entry(4, 16'd30, 1'b1));
		wait_idle();

		write_mode(1'b0);
		entry_backlog.push_back(make_entry(-1, 16'd1, 1'b0));
		entry_backlog.push_back(make_entry(32'h8000_0000, 16'hFFFF, 1'b0));
		entry_backlog.push_back(make_entry(32'h7FFF_FFFF, 16'd3, 1'b0));
		entry_backlog.push_back(make_entry(0, 16'd2, 1'b0));
		entry_backlog.push_back(make_entry(-7, 16'd2, 1'b0));
		entry_backlog.push_back(make_entry(-8, 16'd0, 1'b0));
		entry_backlog.push_back(make_entry(-9, 16'd2, 1'b1));
		entry_backlog.push_back(make_entry(5, 16'd9, 1'b1));
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			write_mode(1'(p ^ (p >> 2)));
			set_pacing(p % 4);
			queue_random_sets(PHASE_ITEMS, 1'(p ^ (p >> 2)));
			wait_idle();
		end

		$display("Checked %0d set results from %0d accepted entries over %0d mode writes,",
			sets_checked, entries_taken, mode_writes);
		$display("with all idle and stall mixes, both key signs and edge-case counts.");
		if (mismatches == 0) begin
			$display("occurrence_count_statistics verification clean");
		end else begin
			$display("occurrence_count_statistics verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/occ_pkg.sv
rtl/occ_front.sv
rtl/occ_queue.sv
rtl/occ_back.sv
rtl/occurrence_count_statistics.sv
dv/tb_occurrence_count_statistics.sv
